@@ rtl/tbss_pkg.sv @@
package tbss_pkg;

    localparam int unsigned DebounceWidth = 4;
    localparam int unsigned SpeedWidth    = 20;
    localparam int unsigned SetpointWidth = SpeedWidth + 1;
    localparam int unsigned RequestWidth  = 2;
    localparam int unsigned StepWidth     = 2;
    localparam int unsigned CfgIndexWidth = 2;

    // Motor request codes
    localparam logic [RequestWidth-1:0] REQ_NONE     = 2'd0;
    localparam logic [RequestWidth-1:0] REQ_STARTUP  = 2'd1;
    localparam logic [RequestWidth-1:0] REQ_SHUTDOWN = 2'd2;

    // Configuration register indexes
    localparam logic [CfgIndexWidth-1:0] CFG_DEBOUNCE   = 2'd0;
    localparam logic [CfgIndexWidth-1:0] CFG_SPEED_LOW  = 2'd1;
    localparam logic [CfgIndexWidth-1:0] CFG_SPEED_MID  = 2'd2;
    localparam logic [CfgIndexWidth-1:0] CFG_SPEED_HIGH = 2'd3;

    localparam logic [DebounceWidth-1:0] DEBOUNCE_RESET = 4'd4;

    // Speed step codes
    localparam logic [StepWidth-1:0] STEP_LOW  = 2'd0;
    localparam logic [StepWidth-1:0] STEP_MID  = 2'd1;
    localparam logic [StepWidth-1:0] STEP_HIGH = 2'd2;

    typedef struct packed {
        logic                     pressed;
        logic [DebounceWidth-1:0] count;
        logic                     fresh;
    } deb_status_t;

    typedef struct packed {
        logic [StepWidth-1:0]            step;
        logic signed [SetpointWidth-1:0] setpoint;
    } speed_status_t;

endpackage

@@ rtl/tbss_debounce.sv @@
module tbss_debounce
(
    input  logic                               level,
    input  logic                               pressed,
    input  logic [tbss_pkg::DebounceWidth-1:0] count,
    input  logic [tbss_pkg::DebounceWidth-1:0] limit,
    output tbss_pkg::deb_status_t              status
);

    logic                               away;
    logic [tbss_pkg::DebounceWidth-1:0] count_inc;

    // Count ticks at the level opposite to the accepted state
    assign away      = pressed ? level : !level;
    assign count_inc = away ? (count + 1'b1) : '0;

    always_comb
    begin
        if (count_inc >= limit)
        begin
            status.pressed = !pressed;
            status.count   = '0;
            status.fresh   = !pressed;
        end
        else
        begin
            status.pressed = pressed;
            status.count   = count_inc;
            status.fresh   = 1'b0;
        end
    end

endmodule

@@ rtl/tbss_speed.sv @@
module tbss_speed
(
    input  logic [tbss_pkg::StepWidth-1:0]  step,
    input  logic                            reverse,
    input  logic [tbss_pkg::SpeedWidth-1:0] speed_low,
    input  logic [tbss_pkg::SpeedWidth-1:0] speed_mid,
    input  logic [tbss_pkg::SpeedWidth-1:0] speed_high,
    output tbss_pkg::speed_status_t         status
);

    logic [tbss_pkg::SpeedWidth-1:0]           mag;
    logic signed [tbss_pkg::SetpointWidth-1:0] mag_ext;

    // Advance the step 0, 1, 2, 0 ...
    always_comb
    begin
        case (step)
            tbss_pkg::STEP_LOW:  status.step = tbss_pkg::STEP_MID;
            tbss_pkg::STEP_MID:  status.step = tbss_pkg::STEP_HIGH;
            default:             status.step = tbss_pkg::STEP_LOW;
        endcase
    end

    always_comb
    begin
        case (status.step)
            tbss_pkg::STEP_LOW: mag = speed_low;
            tbss_pkg::STEP_MID: mag = speed_mid;
            default:            mag = speed_high;
        endcase
    end

    assign mag_ext         = $signed({1'b0, mag});
    assign status.setpoint = reverse ? -mag_ext : mag_ext;

endmodule

@@ rtl/two_button_speed_selector.sv @@
// Two-button speed selector. Each accepted input word is one tick carrying the
// raw active-low levels of buttons A and B and the motor running flag; each
// tick yields exactly one result word. Both buttons are debounced: a change of
// level is taken once it has held for debounce_ticks consecutive ticks (a
// value of 0 acts as 1). A fresh press of A with the motor stopped requests
// start-up, latches reverse direction from B's debounced state and resets the
// speed step; with the motor running it advances the step low, mid, high, low
// and issues the signed setpoint (negated when reverse is latched). A fresh
// press of B while running requests shutdown; when both land on one tick the
// setpoint is issued and the request reads shutdown. The setpoint is 0 on any
// tick that issues none. Rate: one tick per clock cycle while out_stall is low;
// a word is held in the input register until it advances, and its result is
// then loaded into the output register, which drives out_valid. The result
// is computed in a single pass through the debouncers and step logic.
// in_stall rises only while the output register holds a word that downstream
// stalls and the input register is full. Configuration is written through
// cfg_write / cfg_index / cfg_data and must be written only while no word is
// in flight.
module two_button_speed_selector
(
    input  logic                                  clk,
    input  logic                                  rst_n,

    input  logic                                  cfg_write,
    input  logic [tbss_pkg::CfgIndexWidth-1:0]    cfg_index,
    input  logic [tbss_pkg::SpeedWidth-1:0]       cfg_data,

    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic                                  button_a_level,
    input  logic                                  button_b_level,
    input  logic                                  motor_running,

    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic [tbss_pkg::RequestWidth-1:0]     request,
    output logic                                  setpoint_write,
    output logic signed [tbss_pkg::SetpointWidth-1:0] setpoint,
    output logic                                  a_pressed_now,
    output logic                                  b_pressed_now
);

    // Configuration registers
    logic [tbss_pkg::DebounceWidth-1:0] debounce_ticks_reg;
    logic [tbss_pkg::SpeedWidth-1:0]    speed_low_reg;
    logic [tbss_pkg::SpeedWidth-1:0]    speed_mid_reg;
    logic [tbss_pkg::SpeedWidth-1:0]    speed_high_reg;

    // Input register
    logic in_valid_reg;
    logic lev_a_reg;
    logic lev_b_reg;
    logic running_reg;

    // Tick state
    logic                               a_pressed_reg;
    logic [tbss_pkg::DebounceWidth-1:0] a_count_reg;
    logic                               b_pressed_reg;
    logic [tbss_pkg::DebounceWidth-1:0] b_count_reg;
    logic                               reverse_reg;
    logic [tbss_pkg::StepWidth-1:0]     speed_index_reg;

    // Result register
    logic                                      out_valid_reg;
    logic [tbss_pkg::RequestWidth-1:0]         request_reg;
    logic                                      setpoint_write_reg;
    logic signed [tbss_pkg::SetpointWidth-1:0] setpoint_reg;

    // Next values
    logic                                      reverse_next;
    logic [tbss_pkg::StepWidth-1:0]            speed_index_next;
    logic [tbss_pkg::RequestWidth-1:0]         request_next;
    logic                                      setpoint_write_next;
    logic signed [tbss_pkg::SetpointWidth-1:0] setpoint_next;

    logic                               advance;
    logic                               load_in;
    logic [tbss_pkg::DebounceWidth-1:0] limit;
    tbss_pkg::deb_status_t              deb_a;
    tbss_pkg::deb_status_t              deb_b;
    tbss_pkg::speed_status_t            spd;

    // Move the held tick into the result register whenever that register is
    // free or being emptied this cycle.
    assign advance  = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !advance;
    assign load_in  = in_valid && !in_stall;

    // A limit of zero behaves as one
    assign limit = (debounce_ticks_reg == '0) ? {{(tbss_pkg::DebounceWidth-1){1'b0}}, 1'b1}
                                              : debounce_ticks_reg;

    tbss_debounce u_deb_a
    (
        .level   (lev_a_reg),
        .pressed (a_pressed_reg),
        .count   (a_count_reg),
        .limit   (limit),
        .status  (deb_a)
    );

    tbss_debounce u_deb_b
    (
        .level   (lev_b_reg),
        .pressed (b_pressed_reg),
        .count   (b_count_reg),
        .limit   (limit),
        .status  (deb_b)
    );

    tbss_speed u_speed
    (
        .step       (speed_index_reg),
        .reverse    (reverse_reg),
        .speed_low  (speed_low_reg),
        .speed_mid  (speed_mid_reg),
        .speed_high (speed_high_reg),
        .status     (spd)
    );

    // Handle A's fresh press first; B's debouncer sees the old B state, so
    // the direction latch takes B's state from before this tick.
    always_comb
    begin
        reverse_next        = reverse_reg;
        speed_index_next    = speed_index_reg;
        request_next        = tbss_pkg::REQ_NONE;
        setpoint_write_next = 1'b0;
        setpoint_next       = '0;
        if (deb_a.fresh)
        begin
            if (running_reg)
            begin
                speed_index_next    = spd.step;
                setpoint_write_next = 1'b1;
                setpoint_next       = spd.setpoint;
            end
            else
            begin
                reverse_next     = b_pressed_reg;
                speed_index_next = tbss_pkg::STEP_LOW;
                request_next     = tbss_pkg::REQ_STARTUP;
            end
        end
        if (deb_b.fresh && running_reg)
        begin
            request_next = tbss_pkg::REQ_SHUTDOWN;
        end
    end

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_ticks_reg <= tbss_pkg::DEBOUNCE_RESET;
            speed_low_reg      <= '0;
            speed_mid_reg      <= '0;
            speed_high_reg     <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                tbss_pkg::CFG_DEBOUNCE:
                    debounce_ticks_reg <= cfg_data[tbss_pkg::DebounceWidth-1:0];
                tbss_pkg::CFG_SPEED_LOW:  speed_low_reg  <= cfg_data;
                tbss_pkg::CFG_SPEED_MID:  speed_mid_reg  <= cfg_data;
                tbss_pkg::CFG_SPEED_HIGH: speed_high_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Input register: hold the word until it advances
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (load_in)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_in)
        begin
            lev_a_reg   <= button_a_level;
            lev_b_reg   <= button_b_level;
            running_reg <= motor_running;
        end
    end

    // Tick state and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_pressed_reg   <= 1'b0;
            a_count_reg     <= '0;
            b_pressed_reg   <= 1'b0;
            b_count_reg     <= '0;
            reverse_reg     <= 1'b0;
            speed_index_reg <= tbss_pkg::STEP_LOW;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                a_pressed_reg   <= deb_a.pressed;
                a_count_reg     <= deb_a.count;
                b_pressed_reg   <= deb_b.pressed;
                b_count_reg     <= deb_b.count;
                reverse_reg     <= reverse_next;
                speed_index_reg <= speed_index_next;
                out_valid_reg   <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            request_reg        <= request_next;
            setpoint_write_reg <= setpoint_write_next;
            setpoint_reg       <= setpoint_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign request        = request_reg;
    assign setpoint_write = setpoint_write_reg;
    assign setpoint       = setpoint_reg;
    assign a_pressed_now  = a_pressed_reg;
    assign b_pressed_now  = b_pressed_reg;

`ifndef ASSERT_OFF
    // The speed step never reaches the unused code
    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        speed_index_reg != 2'd3)
        else $error("speed step out of range");

    // Tick state moves only when a word advances
    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> ($stable(speed_index_reg) && $stable(a_count_reg)
                      && $stable(b_count_reg) && $stable(reverse_reg)))
        else $error("tick state changed without a word advancing");

    // No setpoint value without a setpoint write
    a_setpoint_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !setpoint_write_reg) |-> (setpoint_reg == '0))
        else $error("setpoint non-zero without a write");

    // Start-up never coincides with a setpoint write
    a_start_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && request_reg == tbss_pkg::REQ_STARTUP) |-> !setpoint_write_reg)
        else $error("start-up issued with a setpoint");

    // Input stalls only while the output is held back
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (in_valid_reg && out_valid_reg && out_stall))
        else $error("input stalled without an output stall");
`endif

endmodule
